// ===== rtl/cnndt_pkg.sv =====
// ----------------------------------------------------------------------------
// Canny NMS / double threshold: shared definitions
// Geometry limits, register indexes, line buffer words and window helpers.
// ----------------------------------------------------------------------------
package cnndt_pkg;

    // Image geometry
    localparam int unsigned MAX_WIDTH  = 1024;
    localparam int unsigned MAX_HEIGHT = 4095;
    localparam int unsigned MIN_DIM    = 3;
    localparam int unsigned COL_W      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int unsigned GW_W       = COL_W + 1;       // latched width, holds MAX_WIDTH
    localparam int unsigned FW_W       = 11;              // frame_width register
    localparam int unsigned FH_W       = 12;              // frame_height register
    localparam int unsigned ROW_W      = FH_W + 2;        // signed row, covers -3 .. height+2

    // Pixel fields
    localparam int unsigned MAG_W      = 8;
    localparam int unsigned DIR_W      = 2;
    localparam int unsigned TDATA_IN_W  = 16;
    localparam int unsigned TDATA_OUT_W = 8;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_THRESHOLD = CFG_IDX_W'(3);

    localparam logic [FW_W-1:0]  RST_FRAME_WIDTH  = FW_W'(640);
    localparam logic [FH_W-1:0]  RST_FRAME_HEIGHT = FH_W'(480);
    localparam logic [MAG_W-1:0] RST_LOW          = MAG_W'(50);
    localparam logic [MAG_W-1:0] RST_HIGH         = MAG_W'(150);

    // Gradient direction codes
    localparam logic [DIR_W-1:0] DIR_0   = DIR_W'(0);
    localparam logic [DIR_W-1:0] DIR_45  = DIR_W'(1);
    localparam logic [DIR_W-1:0] DIR_90  = DIR_W'(2);
    localparam logic [DIR_W-1:0] DIR_135 = DIR_W'(3);

    // Edge map values
    localparam logic [MAG_W-1:0] EDGE_ON  = MAG_W'(255);
    localparam logic [MAG_W-1:0] EDGE_OFF = MAG_W'(0);

    // Pixel position in the frame
    typedef struct packed {
        logic signed [ROW_W-1:0] row;
        logic [COL_W-1:0]        col;
    } t_pos;

    // Magnitude line buffer word: one and two rows back
    typedef struct packed {
        logic [DIR_W-1:0] dir;
        logic [MAG_W-1:0] mag_a;
        logic [MAG_W-1:0] mag_b;
    } t_mag_word;

    // Suppressed line buffer word: one and two rows back
    typedef struct packed {
        logic [MAG_W-1:0] sup_a;
        logic [MAG_W-1:0] sup_b;
    } t_sup_word;

    // Position one row and one column back (width+1 items earlier)
    function automatic t_pos back_off(input t_pos p, input logic [GW_W-1:0] w);
        t_pos b;
        if (p.col != '0) begin
            b.row = p.row - ROW_W'(1);
            b.col = p.col - COL_W'(1);
        end else begin
            b.row = p.row - ROW_W'(2);
            b.col = COL_W'(w - GW_W'(1));
        end
        return b;
    endfunction

endpackage

// ===== rtl/canny_nms_double_threshold.sv =====
// ----------------------------------------------------------------------------
// Canny non-maximum suppression with one-step double threshold
// Raster pixel stream in, binary edge map out, 3x3 windows from line buffers.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                          Payload
//  --------  ---------  ---------------------------------  ---------------------------
//  cfg       in         i_cfg_valid / o_cfg_ready          i_cfg_index, i_cfg_data
//  s_axis    in         i_s_axis_tvalid / o_s_axis_tready  tdata: magnitude, direction
//                                                          tuser: flush
//  m_axis    out        o_m_axis_tvalid / i_m_axis_tready  tdata: edge_res
//                                                          tlast: last_of_frame
//
//  One request is taken per clock while the output does not stall; a window's
//  result passes the input, suppression and threshold stages and the output
//  register. The first 2*width+2 requests of a frame give no result.
//  Two line buffer RAMs of MAX_WIDTH words (magnitude/direction, suppressed
//  values) hold the previous rows; no clearing pass, stale rows are masked.
//  Synchronous active-low reset clears counters and valid flags and loads config defaults.
//  A stalled output holds the whole pipeline and drops o_s_axis_tready.
//
module canny_nms_double_threshold (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,

    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [cnndt_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [cnndt_pkg::CFG_DATA_W-1:0]       i_cfg_data,

    input  logic                                   i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    input  logic [cnndt_pkg::TDATA_IN_W-1:0]       i_s_axis_tdata,  // [7:0] magnitude, [9:8] direction
    input  logic                                   i_s_axis_tuser,  // [0] flush

    output logic                                   o_m_axis_tvalid,
    input  logic                                   i_m_axis_tready,
    output logic [cnndt_pkg::TDATA_OUT_W-1:0]      o_m_axis_tdata,  // [7:0] edge_res
    output logic                                   o_m_axis_tlast
);

    localparam int unsigned MAG_W = cnndt_pkg::MAG_W;
    localparam int unsigned COL_W = cnndt_pkg::COL_W;
    localparam int unsigned GW_W  = cnndt_pkg::GW_W;
    localparam int unsigned FW_W  = cnndt_pkg::FW_W;
    localparam int unsigned FH_W  = cnndt_pkg::FH_W;
    localparam int unsigned ROW_W = cnndt_pkg::ROW_W;
    localparam int unsigned DIR_W = cnndt_pkg::DIR_W;

    // Window indexes: columns newest (right) to oldest (left), rows top to bottom
    localparam int C_NEW = 0;
    localparam int C_CEN = 1;
    localparam int C_OLD = 2;
    localparam int R_TOP = 0;
    localparam int R_MID = 1;
    localparam int R_BOT = 2;

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    logic [FW_W-1:0]  r_cfg_width;
    logic [FH_W-1:0]  r_cfg_height;
    logic [MAG_W-1:0] r_low;
    logic [MAG_W-1:0] r_high;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= cnndt_pkg::RST_FRAME_WIDTH;
            r_cfg_height <= cnndt_pkg::RST_FRAME_HEIGHT;
            r_low        <= cnndt_pkg::RST_LOW;
            r_high       <= cnndt_pkg::RST_HIGH;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                cnndt_pkg::REG_FRAME_WIDTH:    r_cfg_width  <= i_cfg_data[FW_W-1:0];
                cnndt_pkg::REG_FRAME_HEIGHT:   r_cfg_height <= i_cfg_data[FH_W-1:0];
                cnndt_pkg::REG_LOW_THRESHOLD:  r_low        <= i_cfg_data[MAG_W-1:0];
                cnndt_pkg::REG_HIGH_THRESHOLD: r_high       <= i_cfg_data[MAG_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Pipeline advance and frame position counters
    // ------------------------------------------------------------------------
    logic              r_out_valid;
    logic              adv;
    logic              acc;
    logic [COL_W-1:0]  r_ct;
    logic [ROW_W-2:0]  r_rt;
    logic [GW_W-1:0]   r_geo_w;
    logic [FH_W-1:0]   r_geo_h;
    logic [GW_W-1:0]   w_clamp;
    logic [FH_W-1:0]   h_clamp;
    logic [GW_W-1:0]   g_w;
    logic [FH_W-1:0]   g_h;
    logic              first_t;
    logic              last_t;
    logic              wrap_t;

    assign adv             = !r_out_valid || i_m_axis_tready;
    assign acc             = i_s_axis_tvalid && adv;
    assign o_s_axis_tready = adv;

    // Clamp the geometry registers to the supported range
    always_comb begin
        if (int'(r_cfg_width) < int'(cnndt_pkg::MIN_DIM)) begin
            w_clamp = GW_W'(cnndt_pkg::MIN_DIM);
        end else if (int'(r_cfg_width) > int'(cnndt_pkg::MAX_WIDTH)) begin
            w_clamp = GW_W'(cnndt_pkg::MAX_WIDTH);
        end else begin
            w_clamp = GW_W'(r_cfg_width);
        end
        if (int'(r_cfg_height) < int'(cnndt_pkg::MIN_DIM)) begin
            h_clamp = FH_W'(cnndt_pkg::MIN_DIM);
        end else if (int'(r_cfg_height) > int'(cnndt_pkg::MAX_HEIGHT)) begin
            h_clamp = FH_W'(cnndt_pkg::MAX_HEIGHT);
        end else begin
            h_clamp = r_cfg_height;
        end
    end

    // Latch geometry on the first request of a frame
    assign first_t = (r_ct == '0) && (r_rt == '0);
    assign g_w     = first_t ? w_clamp : r_geo_w;
    assign g_h     = first_t ? h_clamp : r_geo_h;
    // Final drain request sits in row height+2, column one
    assign last_t  = (r_rt == ({1'b0, g_h} + (ROW_W-1)'(2))) && (r_ct == COL_W'(1));
    assign wrap_t  = (({1'b0, r_ct} + GW_W'(1)) == g_w);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ct    <= '0;
            r_rt    <= '0;
            r_geo_w <= GW_W'(cnndt_pkg::RST_FRAME_WIDTH);
            r_geo_h <= cnndt_pkg::RST_FRAME_HEIGHT;
        end else if (acc) begin
            if (first_t) begin
                r_geo_w <= w_clamp;
                r_geo_h <= h_clamp;
            end
            if (last_t) begin
                r_ct <= '0;
                r_rt <= '0;
            end else if (wrap_t) begin
                r_ct <= '0;
                r_rt <= r_rt + (ROW_W-1)'(1);
            end else begin
                r_ct <= r_ct + COL_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stage 1: input register, magnitude line buffer read
    // ------------------------------------------------------------------------
    logic                 r1_valid;
    logic [MAG_W-1:0]     r1_mag;
    logic [DIR_W-1:0]     r1_dir;
    cnndt_pkg::t_pos      r1_pos;
    cnndt_pkg::t_pos      s1_pos;
    cnndt_pkg::t_mag_word rd1;
    cnndt_pkg::t_mag_word wr1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (adv) begin
            r1_valid <= acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_mag     <= i_s_axis_tdata[MAG_W-1:0];
            r1_dir     <= i_s_axis_tdata[MAG_W+DIR_W-1:MAG_W];
            r1_pos.row <= $signed({1'b0, r_rt});
            r1_pos.col <= r_ct;
        end
    end

    // Shift the column down one row as it is written back
    always_comb begin
        wr1.dir   = r1_dir;
        wr1.mag_a = r1_mag;
        wr1.mag_b = rd1.mag_a;
    end

    cnndt_ram #(
        .WIDTH ($bits(cnndt_pkg::t_mag_word)),
        .DEPTH (cnndt_pkg::MAX_WIDTH)
    ) u_mag_lines (
        .i_clk     (i_clk),
        .i_wr_en   (adv && r1_valid),
        .i_wr_addr (r1_pos.col),
        .i_wr_data (wr1),
        .i_rd_en   (adv),
        .i_rd_addr (r_ct),
        .o_rd_data (rd1)
    );

    // Centre of the suppression window: one row and one column back
    assign s1_pos = cnndt_pkg::back_off(r1_pos, r_geo_w);

    // ------------------------------------------------------------------------
    // Stage 2: magnitude window, non-maximum suppression
    // ------------------------------------------------------------------------
    logic                    r2_valid;
    cnndt_pkg::t_pos         r2_pos;
    logic [MAG_W-1:0]        r_mw [3][3];
    logic [DIR_W-1:0]        r_dir_new;
    logic [DIR_W-1:0]        r_dir_cen;
    logic signed [ROW_W-1:0] geo_h_s;
    logic                    top_ok;
    logic                    bot_ok;
    logic                    left_ok;
    logic                    right_ok;
    logic                    s_real;
    logic [MAG_W-1:0]        m_cen;
    logic [MAG_W-1:0]        nb_a;
    logic [MAG_W-1:0]        nb_b;
    logic [MAG_W-1:0]        sup;
    cnndt_pkg::t_sup_word    rd2;
    cnndt_pkg::t_sup_word    wr2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (adv) begin
            r2_valid <= r1_valid;
        end
    end

    // Advance the magnitude window by one column per item
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_pos <= s1_pos;
            if (r1_valid) begin
                r_mw[C_OLD]        <= r_mw[C_CEN];
                r_mw[C_CEN]        <= r_mw[C_NEW];
                r_mw[C_NEW][R_BOT] <= r1_mag;
                r_mw[C_NEW][R_MID] <= rd1.mag_a;
                r_mw[C_NEW][R_TOP] <= rd1.mag_b;
                r_dir_new          <= rd1.dir;
                r_dir_cen          <= r_dir_new;
            end
        end
    end

    assign geo_h_s  = $signed({{(ROW_W-FH_W){1'b0}}, r_geo_h});
    assign top_ok   = (r2_pos.row >= ROW_W'(1));
    assign bot_ok   = (r2_pos.row < (geo_h_s - ROW_W'(1)));
    assign left_ok  = (r2_pos.col != '0);
    assign right_ok = (({1'b0, r2_pos.col} + GW_W'(1)) != r_geo_w);
    assign s_real   = (r2_pos.row >= ROW_W'(0)) && (r2_pos.row < geo_h_s);
    assign m_cen    = r_mw[C_CEN][R_MID];

    // Pick the two neighbours along the gradient; outside the image reads zero
    always_comb begin
        case (r_dir_cen)
            cnndt_pkg::DIR_0: begin
                nb_a = right_ok ? r_mw[C_NEW][R_MID] : '0;
                nb_b = left_ok  ? r_mw[C_OLD][R_MID] : '0;
            end
            cnndt_pkg::DIR_45: begin
                nb_a = (top_ok && right_ok) ? r_mw[C_NEW][R_TOP] : '0;
                nb_b = (bot_ok && left_ok)  ? r_mw[C_OLD][R_BOT] : '0;
            end
            cnndt_pkg::DIR_90: begin
                nb_a = bot_ok ? r_mw[C_CEN][R_BOT] : '0;
                nb_b = top_ok ? r_mw[C_CEN][R_TOP] : '0;
            end
            default: begin
                nb_a = (bot_ok && right_ok) ? r_mw[C_NEW][R_BOT] : '0;
                nb_b = (top_ok && left_ok)  ? r_mw[C_OLD][R_TOP] : '0;
            end
        endcase
    end

    // Keep the magnitude only at a strict local maximum
    assign sup = (s_real && (nb_a < m_cen) && (nb_b < m_cen)) ? m_cen : '0;

    always_comb begin
        wr2.sup_a = sup;
        wr2.sup_b = rd2.sup_a;
    end

    cnndt_ram #(
        .WIDTH ($bits(cnndt_pkg::t_sup_word)),
        .DEPTH (cnndt_pkg::MAX_WIDTH)
    ) u_sup_lines (
        .i_clk     (i_clk),
        .i_wr_en   (adv && r2_valid),
        .i_wr_addr (r2_pos.col),
        .i_wr_data (wr2),
        .i_rd_en   (adv),
        .i_rd_addr (s1_pos.col),
        .o_rd_data (rd2)
    );

    // ------------------------------------------------------------------------
    // Stage 3: suppressed window, double threshold
    // ------------------------------------------------------------------------
    logic             r3_valid;
    cnndt_pkg::t_pos  r3_pos;
    logic [MAG_W-1:0] r_sw [3][3];
    logic             q_ok;
    logic             q_border;
    logic             q_last;
    logic             strong_any;
    logic [MAG_W-1:0] v_cen;
    logic [MAG_W-1:0] edge_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (adv) begin
            r3_valid <= r2_valid;
        end
    end

    // Advance the suppressed window by one column per item
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_pos <= cnndt_pkg::back_off(r2_pos, r_geo_w);
            if (r2_valid) begin
                r_sw[C_OLD]        <= r_sw[C_CEN];
                r_sw[C_CEN]        <= r_sw[C_NEW];
                r_sw[C_NEW][R_BOT] <= sup;
                r_sw[C_NEW][R_MID] <= rd2.sup_a;
                r_sw[C_NEW][R_TOP] <= rd2.sup_b;
            end
        end
    end

    assign q_ok     = (r3_pos.row >= ROW_W'(0));
    assign q_border = (r3_pos.row == ROW_W'(0)) || (r3_pos.col == '0) ||
                      (r3_pos.row == (geo_h_s - ROW_W'(1))) ||
                      (({1'b0, r3_pos.col} + GW_W'(1)) == r_geo_w);
    assign q_last   = (r3_pos.row == (geo_h_s - ROW_W'(1))) &&
                      (({1'b0, r3_pos.col} + GW_W'(1)) == r_geo_w);
    assign v_cen    = r_sw[C_CEN][R_MID];

    // Look for a strong value anywhere in the window
    always_comb begin
        strong_any = 1'b0;
        for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
                if (r_sw[c][r] > r_high) begin
                    strong_any = 1'b1;
                end
            end
        end
    end

    // Low test first, then high, then weak pixels: off on the border, else by their neighbours
    always_comb begin
        if (v_cen <= r_low) begin
            edge_val = cnndt_pkg::EDGE_OFF;
        end else if (v_cen >= r_high) begin
            edge_val = cnndt_pkg::EDGE_ON;
        end else if (q_border) begin
            edge_val = cnndt_pkg::EDGE_OFF;
        end else if (strong_any) begin
            edge_val = cnndt_pkg::EDGE_ON;
        end else begin
            edge_val = cnndt_pkg::EDGE_OFF;
        end
    end

    // ------------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------------
    logic [MAG_W-1:0] r_out_edge;
    logic             r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r3_valid && q_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_edge <= edge_val;
            r_out_last <= q_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_edge;
    assign o_m_axis_tlast  = r_out_last;

endmodule

// ===== rtl/cnndt_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module cnndt_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                                       i_clk,
    input  logic                                       i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                           i_wr_data,
    input  logic                                       i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                           o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read, held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sim/tb_canny_nms_double_threshold.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Canny NMS / double threshold block-level testbench
// Streams raster frames of gradient magnitude and direction into the block,
// followed by the drain requests that empty its pipeline, and checks every
// edge map pixel and frame end marker against a cycle-free predictor of
// suppression and one-step hysteresis. Geometry and thresholds change
// between frames, including clamped sizes and crossed thresholds, while both
// stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_canny_nms_double_threshold;
    import cnndt_pkg::*;

    localparam int RING_LEN = 2 * MAX_WIDTH + 4;

    typedef struct packed {
        logic [MAG_W-1:0] edge_val;
        logic             frame_end;
    } t_edge_result;

    // Clamp a geometry register to the range the block latches
    function automatic int dim_clamp(input int v, input int lo, input int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // Edge map predictor and result store
    // ------------------------------------------------------------------------
    class edge_scoreboard;
        logic [FW_W-1:0]  cfg_w;
        logic [FH_W-1:0]  cfg_h;
        logic [MAG_W-1:0] thr_low;
        logic [MAG_W-1:0] thr_high;
        int               geo_w;
        int               geo_h;
        int               col;
        int               row;
        logic [MAG_W-1:0] mag_ring [RING_LEN];
        logic [DIR_W-1:0] dir_ring [RING_LEN];
        logic [MAG_W-1:0] sup_ring [RING_LEN];
        t_edge_result     expected_edges [$];
        int               mismatches;

        function new();
            cfg_w      = RST_FRAME_WIDTH;
            cfg_h      = RST_FRAME_HEIGHT;
            thr_low    = RST_LOW;
            thr_high   = RST_HIGH;
            geo_w      = int'(RST_FRAME_WIDTH);
            geo_h      = int'(RST_FRAME_HEIGHT);
            col        = 0;
            row        = 0;
            mismatches = 0;
            for (int i = 0; i < RING_LEN; i++) begin
                mag_ring[i] = '0;
                dir_ring[i] = '0;
                sup_ring[i] = '0;
            end
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_FRAME_WIDTH:    cfg_w    = data[FW_W-1:0];
                REG_FRAME_HEIGHT:   cfg_h    = data[FH_W-1:0];
                REG_LOW_THRESHOLD:  thr_low  = data[MAG_W-1:0];
                REG_HIGH_THRESHOLD: thr_high = data[MAG_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_edges.size();
        endfunction

        // Magnitude at a position, zero outside the image
        function int mag_near(input int r, input int c);
            if (r < 0 || c < 0 || r >= geo_h || c >= geo_w) return 0;
            return int'(mag_ring[(r * geo_w + c) % RING_LEN]);
        endfunction

        // Keep the magnitude only on a strict maximum along the direction
        function int suppress_at(input int s);
            int r, c, m, dr, dc;
            r = s / geo_w;
            c = s % geo_w;
            m = int'(mag_ring[s % RING_LEN]);
            case (dir_ring[s % RING_LEN])
                DIR_0:   begin dr = 0;  dc = 1; end
                DIR_45:  begin dr = -1; dc = 1; end
                DIR_90:  begin dr = 1;  dc = 0; end
                default: begin dr = 1;  dc = 1; end
            endcase
            if (mag_near(r + dr, c + dc) >= m || mag_near(r - dr, c - dc) >= m) return 0;
            return m;
        endfunction

        // Double threshold with a single hysteresis step over the 3x3 window
        function logic [MAG_W-1:0] classify_at(input int q);
            int r, c, v, p;
            r = q / geo_w;
            c = q % geo_w;
            v = int'(sup_ring[q % RING_LEN]);
            if (v <= int'(thr_low)) return EDGE_OFF;
            if (v >= int'(thr_high)) return EDGE_ON;
            if (r == 0 || c == 0 || r == geo_h - 1 || c == geo_w - 1) return EDGE_OFF;
            for (int i = -1; i <= 1; i++) begin
                for (int j = -1; j <= 1; j++) begin
                    p = q + i * geo_w + j;
                    if (int'(sup_ring[p % RING_LEN]) > int'(thr_high)) return EDGE_ON;
                end
            end
            return EDGE_OFF;
        endfunction

        // Advance the frame position by one accepted request
        function void note_request(input logic [MAG_W-1:0] mag, input logic [DIR_W-1:0] dir);
            int t, total, lag;
            bit frame_done;
            t_edge_result res;
            frame_done = 1'b0;
            if (col == 0 && row == 0) begin
                geo_w = dim_clamp(int'(cfg_w), MIN_DIM, MAX_WIDTH);
                geo_h = dim_clamp(int'(cfg_h), MIN_DIM, MAX_HEIGHT);
            end
            t     = row * geo_w + col;
            total = geo_w * geo_h;
            lag   = geo_w + 1;
            if (t < total) begin
                mag_ring[t % RING_LEN] = mag;
                dir_ring[t % RING_LEN] = dir;
            end
            if (t >= lag && t - lag < total)
                sup_ring[(t - lag) % RING_LEN] = MAG_W'(suppress_at(t - lag));
            if (t >= 2 * lag) begin
                res.edge_val  = classify_at(t - 2 * lag);
                res.frame_end = (t - 2 * lag + 1 == total);
                frame_done    = res.frame_end;
                expected_edges.push_back(res);
            end
            if (frame_done) begin
                col = 0;
                row = 0;
            end else begin
                col++;
                if (col == geo_w) begin
                    col = 0;
                    row++;
                end
            end
        endfunction

        // Compare one output pixel with the oldest expectation
        function void check_result(input logic [MAG_W-1:0] edge_val, input logic frame_end);
            t_edge_result exp_res;
            if (expected_edges.size() == 0) begin
                if (mismatches < 10)
                    $display("[%0t] unexpected result: edge=%0d last=%0b",
                             $realtime, edge_val, frame_end);
                mismatches++;
                return;
            end
            exp_res = expected_edges.pop_front();
            if (edge_val !== exp_res.edge_val || frame_end !== exp_res.frame_end) begin
                if (mismatches < 10)
                    $display("[%0t] mismatch: edge exp=%0d act=%0d, last exp=%0b act=%0b",
                             $realtime, exp_res.edge_val, edge_val,
                             exp_res.frame_end, frame_end);
                mismatches++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block inputs
    // ------------------------------------------------------------------------
    logic                    i_clk     = 1'b0;
    logic                    i_rst_n   = 1'b0;
    logic                    cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data  = '0;
    logic                    s_tvalid  = 1'b0;
    logic [TDATA_IN_W-1:0]   s_tdata   = '0;
    logic                    s_tuser   = 1'b0;
    logic                    m_tready  = 1'b0;

    logic                    cfg_ready;
    logic                    s_tready;
    logic                    m_tvalid;
    logic [TDATA_OUT_W-1:0]  m_tdata;
    logic                    m_tlast;

    edge_scoreboard          board;
    bit                      calm = 1'b0;
    int                      sink_stall = 0;
    int                      random_pixels = 0;
    logic [MAG_W-1:0]        cur_low;
    logic [MAG_W-1:0]        cur_high;

    always #1 i_clk = ~i_clk;

    canny_nms_double_threshold uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast)
    );

    // Idle length: mostly none or short, now and then long
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Check accepted results and stall the output side at random
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready)
            board.check_result(m_tdata, m_tlast);
        if (sink_stall > 0) begin
            sink_stall = sink_stall - 1;
            m_tready <= 1'b0;
        end else begin
            sink_stall = idle_gap();
            if (sink_stall > 0) begin
                sink_stall = sink_stall - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    // Write one register; hold valid high so writes can follow back to back
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        board.write_reg(idx, data);
    endtask

    // Send one pixel or drain request after a random idle gap
    task automatic push_item(input logic [MAG_W-1:0] mag, input logic [DIR_W-1:0] dir,
                             input logic flush);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(TDATA_IN_W - MAG_W - DIR_W){1'b0}}, dir, mag};
        s_tuser  <= flush;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        board.note_request(mag, dir);
    endtask

    // Drop valid, wait for every expected result, then idle beyond the pipeline depth
    task automatic drain_wait();
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Magnitude pattern: uniform, threshold boundaries, or sparse ridges
    function automatic logic [MAG_W-1:0] pick_mag(input int mode);
        if (mode == 1) begin
            case ($urandom_range(0, 7))
                0: return '0;
                1: return cur_low;
                2: return cur_low + 8'd1;
                3: return cur_high - 8'd1;
                4: return cur_high;
                5: return cur_high + 8'd1;
                6: return 8'd255;
                default: return MAG_W'($urandom_range(0, 255));
            endcase
        end
        if (mode == 2) begin
            if ($urandom_range(0, 3) != 0) return MAG_W'($urandom_range(0, int'(cur_low) / 2));
            case ($urandom_range(0, 3))
                0: return cur_high + 8'd1;
                1: return MAG_W'((int'(cur_low) + int'(cur_high)) / 2);
                2: return 8'd255;
                default: return MAG_W'($urandom_range(0, 255));
            endcase
        end
        return MAG_W'($urandom_range(0, 255));
    endfunction

    // Pick thresholds, write all registers, then stream frames and drain
    task automatic run_phase(input logic [CFG_DATA_W-1:0] w_data,
                             input logic [CFG_DATA_W-1:0] h_data,
                             input int frames, input bit counted);
        int w, h, mode;
        calm = ($urandom_range(0, 4) == 0);
        case ($urandom_range(0, 9))
            0: begin cur_low = 8'd0;   cur_high = 8'd255; end
            1: begin cur_low = 8'd255; cur_high = 8'd0;   end
            2: begin cur_low = MAG_W'($urandom_range(0, 255)); cur_high = cur_low; end
            3: begin
                cur_low  = MAG_W'($urandom_range(0, 255));
                cur_high = MAG_W'($urandom_range(0, 255));
            end
            4: begin cur_low = 8'd0;   cur_high = 8'd0;   end
            5: begin cur_low = 8'd255; cur_high = 8'd255; end
            default: begin
                cur_low  = MAG_W'($urandom_range(0, 200));
                cur_high = MAG_W'($urandom_range(int'(cur_low) + 1, 255));
            end
        endcase
        write_reg(REG_FRAME_WIDTH, w_data);
        write_reg(REG_FRAME_HEIGHT, h_data);
        write_reg(REG_LOW_THRESHOLD, {4'($urandom_range(0, 15)), cur_low});
        write_reg(REG_HIGH_THRESHOLD, {4'($urandom_range(0, 15)), cur_high});
        cfg_valid <= 1'b0;
        w = dim_clamp(int'(w_data[FW_W-1:0]), MIN_DIM, MAX_WIDTH);
        h = dim_clamp(int'(h_data), MIN_DIM, MAX_HEIGHT);
        // Frames follow each other with no drain wait while the geometry holds
        repeat (frames) begin
            mode = $urandom_range(0, 2);
            for (int i = 0; i < w * h; i++) begin
                push_item(pick_mag(mode), DIR_W'($urandom_range(0, 3)),
                          $urandom_range(0, 19) == 0);
                if (counted) random_pixels++;
            end
            for (int i = 0; i < 2 * w + 2; i++)
                push_item(MAG_W'($urandom_range(0, 255)), DIR_W'($urandom_range(0, 3)),
                          $urandom_range(0, 19) != 0);
        end
        drain_wait();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int phase_no;
        int w, h;
        board = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed 3x3 frame: clamped geometry, weak centre next to a strong corner
        cur_low  = 8'd100;
        cur_high = 8'd200;
        write_reg(REG_FRAME_WIDTH, 12'h800);
        write_reg(REG_FRAME_HEIGHT, 12'd2);
        write_reg(REG_LOW_THRESHOLD, 12'hF64);
        write_reg(REG_HIGH_THRESHOLD, 12'd200);
        cfg_valid <= 1'b0;
        push_item(8'd255, DIR_0,   1'b0);
        push_item(8'd0,   DIR_45,  1'b1);
        push_item(8'd210, DIR_90,  1'b0);
        push_item(8'd120, DIR_135, 1'b0);
        push_item(8'd150, DIR_0,   1'b0);
        push_item(8'd60,  DIR_0,   1'b0);
        push_item(8'd0,   DIR_45,  1'b0);
        push_item(8'd255, DIR_135, 1'b1);
        push_item(8'd100, DIR_90,  1'b0);
        // Drain, with one request that claims to be a pixel
        for (int i = 0; i < 8; i++)
            push_item((i == 3) ? 8'd255 : 8'd0, DIR_135, i != 3);
        drain_wait();

        // Random phases, with the largest geometries dropped in a few times
        phase_no = 0;
        while (random_pixels < 2000) begin
            case (phase_no)
                2: run_phase(12'h7FF, 12'h000, 1, 1'b0);
                5: run_phase(12'h803, 12'hFFF, 1, 1'b0);
                8: run_phase(12'd1024, 12'd3, 1, 1'b0);
                default: begin
                    w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
                    h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
                    run_phase({1'($urandom_range(0, 1)), FW_W'(w)}, CFG_DATA_W'(h),
                              $urandom_range(1, 3), 1'b1);
                end
            endcase
            phase_no++;
        end

        repeat (16) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog well beyond the slowest legal run
    initial begin
        #(30_000_000);
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/cnndt_pkg.sv
rtl/cnndt_ram.sv
rtl/canny_nms_double_threshold.sv
sim/tb_canny_nms_double_threshold.sv
